// File: hdl/crc8_command_frame_checker_core_macros.svh
// assertion helpers for the crc-8 command frame checker
`ifndef CRC8_COMMAND_FRAME_CHECKER_CORE_MACROS_SVH
`define CRC8_COMMAND_FRAME_CHECKER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// next-cycle implication
`define CFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// File: hdl/crc8cfc_pkg.sv
package crc8cfc_pkg;

  localparam logic [7:0] CRC_POLY       = 8'h31;
  localparam logic [7:0] CRC_INIT       = 8'h00;
  localparam logic [7:0] CRC_MSB        = 8'h80;
  localparam logic [7:0] HEADER_DEFAULT = 8'hAA;
  localparam logic [8:0] POS_MAX        = 9'd511;
  localparam logic [8:0] PAYLOAD_START  = 9'd3;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_BIN   = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_CRC_BAD   = 3'd4;

  // crc check outcome
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_OK   = 2'd1;
  localparam logic [1:0] VERDICT_BAD  = 2'd2;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
    logic [2:0] status;
  } result_t;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/crc8_command_frame_checker_core.sv
// channel     | dir | tdata                        | tuser    | tlast
// s_axis      | in  | in_byte                      | -        | in_last
// m_axis      | out | out_byte, out_index,          | out_kind | -
//             |     | payload_length, frame_status |          |
// cfg         | in  | cfg_we / cfg_wdata write frame_header, no read-back
//
// one byte transfer is taken per cycle while s_axis_tready is high; its crc update,
// field capture and result are worked out in one pass of xor and compare logic
// into the result register, or into the skid register while m_axis is stalled
// rst is synchronous and active high: packet state cleared, frame_header to 0xaa
// a two-entry output stage (result register plus skid register) keeps
// s_axis_tready high while one result waits; it drops only when both hold data
module crc8_command_frame_checker_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,      // frame_header
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [15:8] out_index,
                                      // [23:16] payload_length, [26:24] frame_status
  output logic        m_axis_tuser    // out_kind
);
  import crc8cfc_pkg::*;

  // configuration register
  logic [7:0] frame_header;

  // per-packet state
  logic [8:0] byte_position;
  logic [7:0] running_crc;
  logic [7:0] command_id;
  logic [7:0] declared_length;
  logic       header_matched;
  logic [1:0] crc_verdict;

  // output stage
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic       in_fire;
  logic [7:0] crc_step;
  logic [8:0] crc_pos;
  logic       is_payload;
  logic       header_now;
  logic [7:0] command_now;
  logic [7:0] length_now;
  logic [1:0] verdict_now;
  logic [2:0] status_now;
  logic       produce;
  result_t    res;

  logic [8:0] byte_position_next;
  logic [7:0] running_crc_next;

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign crc_step = crc8_byte(running_crc, s_axis_tdata);
  assign crc_pos  = PAYLOAD_START + {1'b0, declared_length};

  // field capture as seen by this byte, including its own contribution
  always_comb begin
    header_now  = header_matched;
    command_now = command_id;
    length_now  = declared_length;
    verdict_now = crc_verdict;
    is_payload  = 1'b0;
    running_crc_next = running_crc;
    if (byte_position == 9'd0) begin
      header_now       = (s_axis_tdata == frame_header);
      running_crc_next = crc_step;
    end else if (byte_position == 9'd1) begin
      command_now      = s_axis_tdata;
      running_crc_next = crc_step;
    end else if (byte_position == 9'd2) begin
      length_now       = s_axis_tdata;
      running_crc_next = crc_step;
    end else if (byte_position < crc_pos) begin
      is_payload       = 1'b1;
      running_crc_next = crc_step;
    end else if (byte_position == crc_pos) begin
      verdict_now = (s_axis_tdata == running_crc) ? VERDICT_OK : VERDICT_BAD;
    end
  end

  // saturating byte count
  assign byte_position_next = (byte_position != POS_MAX) ? byte_position + 9'd1
                                                         : byte_position;

  // status priority: not binary, short, truncated, crc mismatch
  always_comb begin
    if (!header_now) begin
      status_now = ST_NOT_BIN;
    end else if (byte_position < PAYLOAD_START) begin
      status_now = ST_SHORT;
    end else if (verdict_now == VERDICT_NONE) begin
      status_now = ST_TRUNCATED;
    end else if (verdict_now == VERDICT_BAD) begin
      status_now = ST_CRC_BAD;
    end else begin
      status_now = ST_OK;
    end
  end

  // a last byte gives only the report, even inside the payload
  always_comb begin
    if (s_axis_tlast) begin
      res.kind   = KIND_STATUS;
      res.data   = command_now;
      res.index  = 8'd0;
      res.length = length_now;
      res.status = status_now;
    end else begin
      res.kind   = KIND_PAYLOAD;
      res.data   = s_axis_tdata;
      res.index  = 8'(byte_position - PAYLOAD_START);
      res.length = declared_length;
      res.status = ST_OK;
    end
  end

  assign produce = in_fire && (s_axis_tlast || (is_payload && header_matched));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_header <= HEADER_DEFAULT;
    end else if (cfg_we) begin
      frame_header <= cfg_wdata;
    end
  end

  // packet state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 9'd0;
      running_crc     <= CRC_INIT;
      command_id      <= 8'd0;
      declared_length <= 8'd0;
      header_matched  <= 1'b0;
      crc_verdict     <= VERDICT_NONE;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        byte_position   <= 9'd0;
        running_crc     <= CRC_INIT;
        command_id      <= 8'd0;
        declared_length <= 8'd0;
        header_matched  <= 1'b0;
        crc_verdict     <= VERDICT_NONE;
      end else begin
        byte_position   <= byte_position_next;
        running_crc     <= running_crc_next;
        command_id      <= command_now;
        declared_length <= length_now;
        header_matched  <= header_now;
        crc_verdict     <= verdict_now;
      end
    end
  end

  // result register with skid behind it; skid drains first to keep order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (produce) begin
      skid_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_data.kind;
  assign m_axis_tdata  = {5'd0, out_data.status, out_data.length,
                          out_data.index, out_data.data};

endmodule

// File: hdl/crc8cfc_checker.sv
`include "crc8_command_frame_checker_core_macros.svh"

module crc8cfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [7:0]  cfg_wdata,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import crc8cfc_pkg::*;

  logic [7:0] mon_index;
  logic [7:0] mon_length;
  logic [2:0] mon_status;
  logic       mon_payload;
  logic       mon_report;

  assign mon_index   = m_axis_tdata[15:8];
  assign mon_length  = m_axis_tdata[23:16];
  assign mon_status  = m_axis_tdata[26:24];
  assign mon_payload = m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD);
  assign mon_report  = m_axis_tvalid && (m_axis_tuser == KIND_STATUS);

  // a stalled result holds
  `CFC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // payload bytes carry ok status and lie inside the declared length
  `CFC_ASSERT_NOW(a_payload_status, mon_payload, mon_status == ST_OK)
  `CFC_ASSERT_NOW(a_payload_index, mon_payload, mon_index < mon_length)
  // reports carry index zero and a defined status code
  `CFC_ASSERT_NOW(a_report_index, mon_report, mon_index == 8'd0)
  `CFC_ASSERT_NOW(a_report_code, mon_report,
                  mon_status == ST_OK || mon_status == ST_NOT_BIN ||
                  mon_status == ST_SHORT || mon_status == ST_TRUNCATED ||
                  mon_status == ST_CRC_BAD)

endmodule

bind crc8_command_frame_checker_core crc8cfc_checker u_crc8cfc_checker (.*);

// File: dv/frame_result_checker.sv
`timescale 1ns / 1ps

package frame_tb_pkg;

  // crc-8 advanced by one byte, fed one bit at a time from the msb
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0} ^ (fb ? crc8cfc_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

endpackage

module frame_result_checker
  import crc8cfc_pkg::*;
  import frame_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          error_count,
  output int          pending_count,
  output int          payload_seen,
  output int          reports_seen,
  output logic [4:0]  status_seen
);

  // frame state as the block should hold it
  logic [7:0] header_byte;
  logic [8:0] byte_pos;
  logic [7:0] crc_acc;
  logic [7:0] cmd_id;
  logic [7:0] len_decl;
  logic       hdr_ok;
  logic [1:0] verdict;

  result_t    expected_results[$];
  int         fails = 0;
  int         payload_cnt = 0;
  int         report_cnt = 0;
  logic [4:0] status_mask = '0;

  function automatic void clear_frame();
    byte_pos = '0;
    crc_acc  = CRC_INIT;
    cmd_id   = '0;
    len_decl = '0;
    hdr_ok   = 1'b0;
    verdict  = VERDICT_NONE;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, got);
      fails++;
    end
  endfunction

  // works out what one accepted byte should produce
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [8:0] crc_at;
    logic [8:0] offset;
    logic       in_payload;
    result_t    r;
    crc_at     = PAYLOAD_START + {1'b0, len_decl};
    in_payload = 1'b0;
    if (byte_pos == 9'd0) begin
      hdr_ok  = (b == header_byte);
      crc_acc = crc8_feed(crc_acc, b);
    end else if (byte_pos == 9'd1) begin
      cmd_id  = b;
      crc_acc = crc8_feed(crc_acc, b);
    end else if (byte_pos == 9'd2) begin
      len_decl = b;
      crc_acc  = crc8_feed(crc_acc, b);
    end else if (byte_pos < crc_at) begin
      in_payload = 1'b1;
      crc_acc    = crc8_feed(crc_acc, b);
    end else if (byte_pos == crc_at) begin
      verdict = (b == crc_acc) ? VERDICT_OK : VERDICT_BAD;
    end

    if (last) begin
      r.kind   = KIND_STATUS;
      r.data   = cmd_id;
      r.index  = '0;
      r.length = len_decl;
      if (!hdr_ok) begin
        r.status = ST_NOT_BIN;
      end else if (byte_pos < 9'd3) begin
        r.status = ST_SHORT;
      end else if (verdict == VERDICT_NONE) begin
        r.status = ST_TRUNCATED;
      end else if (verdict == VERDICT_BAD) begin
        r.status = ST_CRC_BAD;
      end else begin
        r.status = ST_OK;
      end
      expected_results.insert(expected_results.size(), r);
      clear_frame();
    end else begin
      if (in_payload && hdr_ok) begin
        offset   = byte_pos - PAYLOAD_START;
        r.kind   = KIND_PAYLOAD;
        r.data   = b;
        r.index  = offset[7:0];
        r.length = len_decl;
        r.status = ST_OK;
        expected_results.insert(expected_results.size(), r);
      end
      if (byte_pos != POS_MAX) begin
        byte_pos = byte_pos + 9'd1;
      end
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      header_byte = HEADER_DEFAULT;
      clear_frame();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        header_byte = cfg_wdata;
      end
      // results first: a result never belongs to a byte taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual tuser %0d tdata 0x%08h",
                   $time, m_axis_tuser, m_axis_tdata);
          fails++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_kind", {7'd0, want.kind}, {7'd0, m_axis_tuser});
          compare_field("out_byte", want.data, m_axis_tdata[7:0]);
          compare_field("out_index", want.index, m_axis_tdata[15:8]);
          compare_field("payload_length", want.length, m_axis_tdata[23:16]);
          compare_field("frame_status", {5'd0, want.status}, {5'd0, m_axis_tdata[26:24]});
          compare_field("tdata padding", 8'h00, {3'd0, m_axis_tdata[31:27]});
          if (want.kind == KIND_STATUS) begin
            report_cnt++;
            status_mask[want.status] = 1'b1;
          end else begin
            payload_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(s_axis_tdata, s_axis_tlast);
      end
    end
    error_count   <= fails;
    pending_count <= expected_results.size();
    payload_seen  <= payload_cnt;
    reports_seen  <= report_cnt;
    status_seen   <= status_mask;
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import crc8cfc_pkg::*;
  import frame_tb_pkg::*;

  // cycles without any transfer before the run is called hung
  localparam int IDLE_LIMIT  = 5000;
  // long receiver hold-off, enough to fill the two-entry output stage
  localparam int HOLD_CYCLES = 200;
  // bytes offered per random phase
  localparam int PHASE_BYTES = 300;

  typedef enum int {
    PK_GOOD,
    PK_TRAILING,
    PK_BAD_CRC,
    PK_TRUNCATED,
    PK_SHORT,
    PK_FOREIGN,
    PK_NOISE,
    PK_LONG
  } packet_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int          error_count;
  int          pending_count;
  int          payload_seen;
  int          reports_seen;
  logic [4:0]  status_seen;

  // knobs shared between the sender and receiver processes
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_len = 0;

  int          bytes_sent = 0;
  int          packets_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  cur_header = HEADER_DEFAULT;
  logic [7:0]  frame_buf[$];

  always #5 clk = ~clk;

  crc8_command_frame_checker_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // watches both channels, predicts every result and compares
  frame_result_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .pending_count (pending_count),
    .payload_seen  (payload_seen),
    .reports_seen  (reports_seen),
    .status_seen   (status_seen)
  );

  // receiver: random stalls, or one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len - 1) @(posedge clk);
        hold_len = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: resets on every transfer, on either channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // add one byte at the end of the packet buffer
  function automatic void buf_append(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endfunction

  // offer one byte, with random idle cycles first; returns at the accepting edge
  task automatic push_byte(input logic [7:0] b, input logic last);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    // tready is sampled mid-cycle, where it is settled
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic append_crc();
    logic [7:0] crc;
    crc = CRC_INIT;
    foreach (frame_buf[i]) begin
      crc = crc8_feed(crc, frame_buf[i]);
    end
    buf_append(crc);
  endtask

  // send the buffer as one packet, tlast on its final byte
  task automatic send_frame_buf();
    foreach (frame_buf[i]) begin
      push_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
    packets_sent++;
  endtask

  task automatic send_packet(input packet_kind_t kind);
    logic [7:0] len;
    logic [7:0] flip;
    int         pick;
    int         n;
    pick = $urandom_range(99);
    // mostly short payloads, now and then a long one
    if (kind == PK_LONG) begin
      len = 8'd255;
    end else if (pick < 85) begin
      len = 8'($urandom_range(8));
    end else if (pick < 97) begin
      len = 8'($urandom_range(40, 9));
    end else begin
      len = 8'($urandom_range(255, 41));
    end
    if (kind == PK_TRUNCATED && len == 8'd0) begin
      len = 8'd1;
    end

    frame_buf.delete();
    buf_append(cur_header);
    buf_append(8'($urandom_range(255)));
    buf_append(len);
    for (int i = 0; i < len; i++) begin
      buf_append(8'($urandom_range(255)));
    end
    append_crc();

    case (kind)
      PK_TRAILING: begin
        n = $urandom_range(6, 1);
        repeat (n) buf_append(8'($urandom_range(255)));
      end
      PK_BAD_CRC: begin
        flip = 8'($urandom_range(255, 1));
        frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ flip;
      end
      PK_TRUNCATED: begin
        // ends somewhere in the payload, before the crc byte
        n = $urandom_range(3 + int'(len), 4);
        while (frame_buf.size() > n) frame_buf.pop_back();
      end
      PK_SHORT: begin
        n = $urandom_range(3, 1);
        while (frame_buf.size() > n) frame_buf.pop_back();
      end
      PK_FOREIGN: begin
        flip = 8'($urandom_range(255, 1));
        frame_buf[0] = cur_header ^ flip;
      end
      PK_NOISE: begin
        n = $urandom_range(12, 1);
        frame_buf.delete();
        repeat (n) buf_append(8'($urandom_range(255)));
      end
      PK_LONG: begin
        // runs well past the 511-byte position limit
        while (frame_buf.size() < 600) buf_append(8'($urandom_range(255)));
      end
      default: begin
      end
    endcase
    send_frame_buf();
  endtask

  task automatic send_random_packet();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      send_packet(PK_GOOD);
    end else if (r < 45) begin
      send_packet(PK_TRAILING);
    end else if (r < 60) begin
      send_packet(PK_BAD_CRC);
    end else if (r < 72) begin
      send_packet(PK_TRUNCATED);
    end else if (r < 80) begin
      send_packet(PK_SHORT);
    end else if (r < 90) begin
      send_packet(PK_FOREIGN);
    end else begin
      send_packet(PK_NOISE);
    end
  endtask

  // stop offering, let every expected result come out, then allow the pipe to empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_header = value;
  endtask

  task automatic run_phase(input logic [7:0] header, input int idle_pct, input int stall_pct,
                           input bit pressure, input bit with_long);
    int start;
    write_header(header);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    // receiver holds off while the sender keeps offering bytes
    if (pressure) begin
      hold_len = HOLD_CYCLES;
    end
    if (with_long) begin
      send_packet(PK_LONG);
    end
    while (bytes_sent - start < PHASE_BYTES) begin
      send_random_packet();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed packets under the reset header 0xaa
    // good frame with an empty payload
    frame_buf = '{8'hAA, 8'h00, 8'h00};
    append_crc();
    send_frame_buf();
    // one-byte packet
    frame_buf = '{8'hAA};
    send_frame_buf();
    // three bytes, still too short
    frame_buf = '{8'hAA, 8'hFF, 8'h01};
    send_frame_buf();
    // wrong header
    frame_buf = '{8'h00, 8'hFF};
    send_frame_buf();
    // good frame, payload at both byte extremes
    frame_buf = '{8'hAA, 8'h5A, 8'h02, 8'h00, 8'hFF};
    append_crc();
    send_frame_buf();
    // crc byte inverted
    frame_buf = '{8'hAA, 8'h01, 8'h00};
    append_crc();
    frame_buf[3] = ~frame_buf[3];
    send_frame_buf();
    // last byte lands inside the payload
    frame_buf = '{8'hAA, 8'h80, 8'h03, 8'h7F};
    send_frame_buf();
    drain();

    // header extremes, idle and stall mixes, one pressure hold-off, one overlong packet
    run_phase(8'h00, 0, 0, 1'b1, 1'b0);
    run_phase(8'hFF, 45, 0, 1'b0, 1'b0);
    run_phase(8'($urandom_range(254, 1)), 0, 45, 1'b0, 1'b1);
    run_phase(HEADER_DEFAULT, 37, 37, 1'b0, 1'b0);

    $display("covered %0d packets / %0d bytes over five header settings and four flow mixes",
             packets_sent, bytes_sent);
    $display("checked %0d payload transfers and %0d status reports, status codes hit %b",
             payload_seen, reports_seen, status_seen);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
